// ===== hw/rtl/ecpa_pkg.sv =====
// Shared constants, handshake structs and modular add/subtract helpers for the
// affine point adder. No dependencies; used by ecpa_mulmod and ec_affine_point_add.
`default_nettype none

package ecpa_pkg;

    // Width of one field element.
    localparam int FIELD_BITS = 31;

    // Counter width for one pass of the bit-serial multiplier.
    localparam int MUL_CNT_W = $clog2(FIELD_BITS + 1);

    // Stream packing: four coordinates in, two coordinates out, padded to bytes.
    localparam int S_DATA_W = ((4 * FIELD_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * FIELD_BITS + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic CFG_CURVE_A = 1'b0;
    localparam logic CFG_PRIME   = 1'b1;

    // Smallest modulus the block works with.
    localparam logic [FIELD_BITS-1:0] MIN_PRIME = FIELD_BITS'(3);

    // Constant factor of the doubling slope.
    localparam logic [FIELD_BITS-1:0] TRIPLE_K = FIELD_BITS'(3);

    typedef logic [FIELD_BITS-1:0] felem_t;

    // Request to the modular multiplier: start pulse and both operands.
    typedef struct packed {
        logic   start;
        felem_t x;
        felem_t y;
    } mul_req_t;

    // Answer from the modular multiplier: one-cycle done pulse and product.
    typedef struct packed {
        logic   done;
        felem_t product;
    } mul_rsp_t;

    // (a + b) mod m for a, b already below m.
    function automatic felem_t mod_add(input felem_t a, input felem_t b, input felem_t m);
        logic [FIELD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[FIELD_BITS-1:0];
    endfunction

    // (a - b) mod m for a, b already below m.
    function automatic felem_t mod_sub(input felem_t a, input felem_t b, input felem_t m);
        felem_t d;
        if (a >= b) begin
            d = a - b;
        end else begin
            d = a + (m - b);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ecpa_mulmod.sv =====
// Bit-serial modular multiplier: scans one bit of y per cycle, most significant first.
// Depends on ecpa_pkg for widths and the request/answer structs.
`default_nettype none

module ecpa_mulmod (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire ecpa_pkg::mul_req_t               req,
    input  wire logic [ecpa_pkg::FIELD_BITS-1:0]  modulus,
    output ecpa_pkg::mul_rsp_t                    rsp
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [ecpa_pkg::FIELD_BITS-1:0]   acc_reg;
    logic [ecpa_pkg::FIELD_BITS-1:0]   x_reg;
    logic [ecpa_pkg::FIELD_BITS-1:0]   y_reg;
    logic [ecpa_pkg::MUL_CNT_W-1:0]    cnt_reg;

    logic [ecpa_pkg::FIELD_BITS:0]     dbl;
    logic [ecpa_pkg::FIELD_BITS:0]     dbl_red;
    logic [ecpa_pkg::FIELD_BITS-1:0]   addend;
    logic [ecpa_pkg::FIELD_BITS:0]     sum;
    logic [ecpa_pkg::FIELD_BITS:0]     sum_red;

    // One step: acc = 2*acc + bit*x, each term folded back below the modulus.
    always_comb begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
        addend  = y_reg[ecpa_pkg::FIELD_BITS-1] ? x_reg : '0;
        sum     = {1'b0, dbl_red[ecpa_pkg::FIELD_BITS-1:0]} + {1'b0, addend};
        sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
    end

    // Control: a pass runs for FIELD_BITS steps, then done pulses for one cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ecpa_pkg::MUL_CNT_W'(ecpa_pkg::FIELD_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - ecpa_pkg::MUL_CNT_W'(1);
                if (cnt_reg == ecpa_pkg::MUL_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: operands are captured at start, y shifts out one bit per step.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg <= '0;
            x_reg   <= req.x;
            y_reg   <= req.y;
        end else if (busy_reg) begin
            acc_reg <= sum_red[ecpa_pkg::FIELD_BITS-1:0];
            y_reg   <= {y_reg[ecpa_pkg::FIELD_BITS-2:0], 1'b0};
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

    // A new pass is only started once the previous one has finished.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");

    // A finished product is always reduced.
    a_done_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (acc_reg < modulus))
        else $error("multiplier product not below modulus");

    // The done pulse comes only once the pass has ended.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("multiplier done while still busy");

endmodule

`default_nettype wire

// ===== hw/rtl/ec_affine_point_add.sv =====
// Affine point adder over a prime field: sequencer, operand registers and output stage.
// Depends on ecpa_pkg and instantiates ecpa_mulmod.
//
// Usage: each input beat on s_* carries two affine points P and Q; one result beat on m_*
// carries P + Q, or the point at infinity flagged in m_tuser with zero coordinates.
// curve_coeff_a (index 0) and field_prime (index 1) are to be written through cfg_* while
// idle; the block itself does not enforce this. A prime below 3 is used as 3.
// All multiplications go through one bit-serial modular multiplier, one operand bit per
// cycle, each one launched by a start pulse from the sequencer.
// An item runs five reductions on entry, two doubling-slope multiplications when P = Q, a
// Fermat inversion (one squaring per exponent bit above the lowest, one multiplication
// per set bit of p - 2) and three final multiplications, plus a handful of add/subtract
// steps. Primes with fewer set bits or fewer bits take less time, and a point at infinity
// leaves after the reductions.
// One item is worked on at a time; s_tready is high only while the sequencer is idle.
// The finished result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver holds the sequencer only when a second result is ready.
// Reset (aresetn, synchronous, active low) returns curve_coeff_a to 0, field_prime to all
// ones, empties the output register and drops any item in progress.
`default_nettype none

module ec_affine_point_add (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write port.
    input  wire logic                                cfg_wr_en,
    input  wire logic                                cfg_index,
    input  wire logic [ecpa_pkg::FIELD_BITS-1:0]     cfg_wr_data,
    // Input points. tdata: p_x, p_y, q_x, q_y, zero padding.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [ecpa_pkg::S_DATA_W-1:0]       s_tdata,
    // Result. tdata: sum_x, sum_y, zero padding. tuser: at_infinity.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [ecpa_pkg::M_DATA_W-1:0]            m_tdata,
    output logic                                     m_tuser
);

    localparam int W = ecpa_pkg::FIELD_BITS;
    localparam int RING_N = 5;
    localparam int RED_CNT_W = $clog2(RING_N);

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RED     = 4'd1;
    localparam logic [3:0] S_CLASS   = 4'd2;
    localparam logic [3:0] S_SQ      = 4'd3;
    localparam logic [3:0] S_TRIPLE  = 4'd4;
    localparam logic [3:0] S_ADDA    = 4'd5;
    localparam logic [3:0] S_EXP_MUL = 4'd6;
    localparam logic [3:0] S_EXP_SQ  = 4'd7;
    localparam logic [3:0] S_SLOPE   = 4'd8;
    localparam logic [3:0] S_SSQ     = 4'd9;
    localparam logic [3:0] S_RX1     = 4'd10;
    localparam logic [3:0] S_RX2     = 4'd11;
    localparam logic [3:0] S_DX      = 4'd12;
    localparam logic [3:0] S_RYM     = 4'd13;
    localparam logic [3:0] S_RY      = 4'd14;
    localparam logic [3:0] S_OUT     = 4'd15;

    logic [3:0]            state_reg;
    logic [3:0]            state_next;
    logic                  run_reg;
    logic [RED_CNT_W-1:0]  red_cnt_reg;

    logic [W-1:0]          coeff_a_reg;
    logic [W-1:0]          prime_reg;

    // Ring of operands: raw px, py, qx, qy, a on entry, reduced after five passes.
    logic [W-1:0]          ring_reg [RING_N];
    logic [W-1:0]          mod_reg;
    logic [W-1:0]          num_reg;
    logic [W-1:0]          base_reg;
    logic [W-1:0]          acc_reg;
    logic [W-1:0]          t_reg;
    logic [W-1:0]          e_reg;
    logic                  inf_reg;

    logic                  m_tvalid_reg;
    logic [W-1:0]          sum_x_reg;
    logic [W-1:0]          sum_y_reg;
    logic                  inf_out_reg;

    ecpa_pkg::mul_req_t    mul_req;
    ecpa_pkg::mul_rsp_t    mul_rsp;
    logic                  mul_state;
    logic                  mul_fin;
    logic                  in_beat;
    logic                  out_load;
    logic                  exp_skip;
    logic                  exp_last;
    logic                  eq_x;
    logic                  ysum_zero;

    ecpa_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .modulus (mod_reg),
        .rsp     (mul_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // Exponent bits are consumed from the bottom; stop once none are left above.
    assign exp_skip = (state_reg == S_EXP_MUL) && !e_reg[0];
    assign exp_last = (e_reg[W-1:1] == '0);

    // Point classification on the reduced coordinates.
    assign eq_x      = (ring_reg[0] == ring_reg[2]);
    assign ysum_zero = (ecpa_pkg::mod_add(ring_reg[1], ring_reg[3], mod_reg) == '0);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_req.x = '0;
        mul_req.y = '0;
        mul_state = 1'b1;
        case (state_reg)
            S_RED: begin
                mul_req.x = W'(1);
                mul_req.y = ring_reg[0];
            end
            S_SQ: begin
                mul_req.x = ring_reg[0];
                mul_req.y = ring_reg[0];
            end
            S_TRIPLE: begin
                mul_req.x = num_reg;
                mul_req.y = ecpa_pkg::TRIPLE_K;
            end
            S_EXP_MUL: begin
                mul_req.x = acc_reg;
                mul_req.y = base_reg;
                mul_state = e_reg[0];
            end
            S_EXP_SQ: begin
                mul_req.x = base_reg;
                mul_req.y = base_reg;
            end
            S_SLOPE: begin
                mul_req.x = num_reg;
                mul_req.y = acc_reg;
            end
            S_SSQ: begin
                mul_req.x = num_reg;
                mul_req.y = num_reg;
            end
            S_RYM: begin
                mul_req.x = num_reg;
                mul_req.y = base_reg;
            end
            default: begin
                mul_state = 1'b0;
            end
        endcase
        mul_req.start = mul_state && !run_reg;
    end

    assign mul_fin = mul_state && run_reg && mul_rsp.done;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_beat) state_next = S_RED;
            S_RED: begin
                if (mul_fin && (red_cnt_reg == RED_CNT_W'(RING_N - 1))) begin
                    state_next = S_CLASS;
                end
            end
            S_CLASS: begin
                if (eq_x && ysum_zero) begin
                    state_next = S_OUT;
                end else if (eq_x && (ring_reg[1] == ring_reg[3])) begin
                    state_next = S_SQ;
                end else begin
                    state_next = S_EXP_MUL;
                end
            end
            S_SQ:      if (mul_fin) state_next = S_TRIPLE;
            S_TRIPLE:  if (mul_fin) state_next = S_ADDA;
            S_ADDA:    state_next = S_EXP_MUL;
            S_EXP_MUL: if (mul_fin || exp_skip) state_next = exp_last ? S_SLOPE : S_EXP_SQ;
            S_EXP_SQ:  if (mul_fin) state_next = S_EXP_MUL;
            S_SLOPE:   if (mul_fin) state_next = S_SSQ;
            S_SSQ:     if (mul_fin) state_next = S_RX1;
            S_RX1:     state_next = S_RX2;
            S_RX2:     state_next = S_DX;
            S_DX:      state_next = S_RYM;
            S_RYM:     if (mul_fin) state_next = S_RY;
            S_RY:      state_next = S_OUT;
            S_OUT:     if (out_load) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            run_reg      <= 1'b0;
            red_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            coeff_a_reg  <= '0;
            prime_reg    <= '1;
        end else begin
            state_reg <= state_next;
            if (mul_req.start) begin
                run_reg <= 1'b1;
            end else if (mul_fin) begin
                run_reg <= 1'b0;
            end
            if (in_beat) begin
                red_cnt_reg <= '0;
            end else if ((state_reg == S_RED) && mul_fin) begin
                red_cnt_reg <= red_cnt_reg + RED_CNT_W'(1);
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                if (cfg_index == ecpa_pkg::CFG_CURVE_A) begin
                    coeff_a_reg <= cfg_wr_data;
                end else begin
                    prime_reg <= cfg_wr_data;
                end
            end
        end
    end

    // Operand and result registers, updated by the step that owns them.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    ring_reg[0] <= s_tdata[W-1:0];
                    ring_reg[1] <= s_tdata[2*W-1:W];
                    ring_reg[2] <= s_tdata[3*W-1:2*W];
                    ring_reg[3] <= s_tdata[4*W-1:3*W];
                    ring_reg[4] <= coeff_a_reg;
                    if (prime_reg < ecpa_pkg::MIN_PRIME) begin
                        mod_reg <= ecpa_pkg::MIN_PRIME;
                        e_reg   <= ecpa_pkg::MIN_PRIME - W'(2);
                    end else begin
                        mod_reg <= prime_reg;
                        e_reg   <= prime_reg - W'(2);
                    end
                end
            end
            S_RED: begin
                if (mul_fin) begin
                    for (int i = 0; i < RING_N - 1; i++) begin
                        ring_reg[i] <= ring_reg[i+1];
                    end
                    ring_reg[RING_N-1] <= mul_rsp.product;
                end
            end
            S_CLASS: begin
                inf_reg  <= eq_x && ysum_zero;
                t_reg    <= '0;
                acc_reg  <= (eq_x && ysum_zero) ? '0 : W'(1);
                num_reg  <= ecpa_pkg::mod_sub(ring_reg[3], ring_reg[1], mod_reg);
                base_reg <= ecpa_pkg::mod_sub(ring_reg[2], ring_reg[0], mod_reg);
            end
            S_SQ: begin
                if (mul_fin) num_reg <= mul_rsp.product;
            end
            S_TRIPLE: begin
                if (mul_fin) num_reg <= mul_rsp.product;
            end
            S_ADDA: begin
                num_reg  <= ecpa_pkg::mod_add(num_reg, ring_reg[4], mod_reg);
                base_reg <= ecpa_pkg::mod_add(ring_reg[1], ring_reg[1], mod_reg);
            end
            S_EXP_MUL: begin
                if (mul_fin) acc_reg <= mul_rsp.product;
            end
            S_EXP_SQ: begin
                if (mul_fin) begin
                    base_reg <= mul_rsp.product;
                    e_reg    <= {1'b0, e_reg[W-1:1]};
                end
            end
            S_SLOPE: begin
                if (mul_fin) num_reg <= mul_rsp.product;
            end
            S_SSQ: begin
                if (mul_fin) t_reg <= mul_rsp.product;
            end
            S_RX1: begin
                t_reg <= ecpa_pkg::mod_sub(t_reg, ring_reg[0], mod_reg);
            end
            S_RX2: begin
                t_reg <= ecpa_pkg::mod_sub(t_reg, ring_reg[2], mod_reg);
            end
            S_DX: begin
                base_reg <= ecpa_pkg::mod_sub(ring_reg[0], t_reg, mod_reg);
            end
            S_RYM: begin
                if (mul_fin) acc_reg <= mul_rsp.product;
            end
            S_RY: begin
                acc_reg <= ecpa_pkg::mod_sub(acc_reg, ring_reg[1], mod_reg);
            end
            S_OUT: begin
                if (out_load) begin
                    sum_x_reg   <= t_reg;
                    sum_y_reg   <= acc_reg;
                    inf_out_reg <= inf_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Output beat.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(ecpa_pkg::M_DATA_W - 2 * W){1'b0}}, sum_y_reg, sum_x_reg};
    assign m_tuser  = inf_out_reg;

    // The point at infinity always carries zero coordinates.
    a_inf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("point at infinity with nonzero coordinates");

    // An accepted beat starts the reductions with the multiplier not yet launched.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> ((state_reg == S_RED) && !run_reg))
        else $error("accepted beat did not start the reductions");

    // A waiting result beat holds still while the receiver stalls.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

endmodule

`default_nettype wire

// ===== bench/point_sum_checker.sv =====
`timescale 1ns / 100ps
// Checker for the affine point adder: watches the configuration port and both streams,
// predicts each point sum and compares it with the result beats. Depends on ecpa_pkg.
module point_sum_checker
    import ecpa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [FIELD_BITS-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  m_tuser,
    output int                    fail_count,
    output int                    pending,
    output int                    checked_count,
    output int                    infinity_count
);

    typedef struct packed {
        felem_t x;
        felem_t y;
        logic   inf;
    } point_sum_t;

    // Local copy of the two curve registers.
    felem_t coeff_a;
    felem_t prime;

    point_sum_t expected_sums[$];
    point_sum_t want;

    // base^e mod m by square and multiply.
    function automatic longint unsigned field_pow(input longint unsigned base,
                                                  input longint unsigned e,
                                                  input longint unsigned m);
        longint unsigned acc;
        longint unsigned b;
        longint unsigned k;
        acc = 1 % m;
        b   = base % m;
        k   = e;
        while (k != 0) begin
            if (k[0]) begin
                acc = (acc * b) % m;
            end
            b = (b * b) % m;
            k = k >> 1;
        end
        return acc;
    endfunction

    // Sum of two affine points under the current curve settings.
    function automatic point_sum_t predict_sum(input felem_t px_in, input felem_t py_in,
                                               input felem_t qx_in, input felem_t qy_in);
        longint unsigned m, px, py, qx, qy, a, num, den, slope, rx, ry;
        point_sum_t r;
        m = prime;
        if (m < MIN_PRIME) begin
            m = MIN_PRIME;
        end
        px = px_in % m;
        py = py_in % m;
        qx = qx_in % m;
        qy = qy_in % m;
        a  = coeff_a % m;
        r  = '0;
        // Opposite points give the point at infinity.
        if (px == qx && (py + qy) % m == 0) begin
            r.inf = 1'b1;
            return r;
        end
        if (px == qx && py == qy) begin
            num = ((3 * ((px * px) % m)) % m + a) % m;
            den = (2 * py) % m;
        end else begin
            num = (qy + m - py) % m;
            den = (qx + m - px) % m;
        end
        // A zero denominator inverts to zero, which gives a zero slope.
        slope = (num * field_pow(den, m - 2, m)) % m;
        rx = ((slope * slope) % m + m - (px + qx) % m) % m;
        ry = ((slope * ((px + m - rx) % m)) % m + m - py) % m;
        r.x = felem_t'(rx);
        r.y = felem_t'(ry);
        return r;
    endfunction

    task automatic report_field(input string name, input longint unsigned exp_v,
                                input longint unsigned got_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        fail_count = fail_count + 1;
    endtask

    // Track register writes, queue predictions on input beats, check result beats.
    always @(posedge aclk) begin
        if (!aresetn) begin
            coeff_a <= '0;
            prime   <= '1;
            expected_sums.delete();
            pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_CURVE_A) begin
                    coeff_a <= cfg_wr_data;
                end else begin
                    prime <= cfg_wr_data;
                end
            end
            if (s_tvalid && s_tready) begin
                expected_sums.push_back(predict_sum(s_tdata[0 +: FIELD_BITS],
                                                    s_tdata[FIELD_BITS +: FIELD_BITS],
                                                    s_tdata[2*FIELD_BITS +: FIELD_BITS],
                                                    s_tdata[3*FIELD_BITS +: FIELD_BITS]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected result beat, got x=%0d y=%0d inf=%0d", $time,
                             m_tdata[0 +: FIELD_BITS], m_tdata[FIELD_BITS +: FIELD_BITS],
                             m_tuser);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_sums.pop_front();
                    if (m_tdata[0 +: FIELD_BITS] !== want.x) begin
                        report_field("sum_x", want.x, m_tdata[0 +: FIELD_BITS]);
                    end
                    if (m_tdata[FIELD_BITS +: FIELD_BITS] !== want.y) begin
                        report_field("sum_y", want.y, m_tdata[FIELD_BITS +: FIELD_BITS]);
                    end
                    if (m_tuser !== want.inf) begin
                        report_field("at_infinity", want.inf, m_tuser);
                    end
                    checked_count = checked_count + 1;
                    if (want.inf) begin
                        infinity_count = infinity_count + 1;
                    end
                end
            end
            pending <= expected_sums.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the affine point adder bench: clock, reset, curve settings and point stimulus.
// Depends on ecpa_pkg, ec_affine_point_add and point_sum_checker.
module testbench;
    import ecpa_pkg::*;

    localparam felem_t COORD_MAX = 31'd2147483646;
    localparam felem_t PRIME_MAX = 31'd2147483647;
    localparam int     PHASE_COUNT = 9;
    localparam int     ITEMS_PER_PHASE = 32;

    typedef enum int {
        PAIR_GENERIC,
        PAIR_DOUBLE,
        PAIR_NEGATED,
        PAIR_SHARED_X
    } pair_kind_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_index = CFG_CURVE_A;
    logic [FIELD_BITS-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;

    int fail_count;
    int pending;
    int checked_count;
    int infinity_count;

    // Idle odds: 1 in idle_odds on input, 1 in 2*idle_odds on output; 0 turns idling off.
    int     idle_odds = 4;
    int     stall_left = 0;
    int     settings_used = 1;
    felem_t cur_prime = PRIME_MAX;

    ec_affine_point_add u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    point_sum_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .infinity_count(infinity_count)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Receiver stalls come in bursts of random length.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic longint unsigned field_modulus();
        return (cur_prime < MIN_PRIME) ? MIN_PRIME : cur_prime;
    endfunction

    // Adds a random multiple of the modulus while the value stays in range.
    function automatic felem_t alias_of(input longint unsigned v);
        longint unsigned m;
        longint unsigned kmax;
        m    = field_modulus();
        kmax = (COORD_MAX - v) / m;
        return felem_t'(v + m * $urandom_range(0, kmax));
    endfunction

    // Mostly reduced coordinates, some drawn from the whole field range.
    function automatic felem_t pick_coord();
        if ($urandom_range(0, 3) == 0) begin
            return felem_t'($urandom_range(0, COORD_MAX));
        end
        return felem_t'($urandom_range(0, field_modulus() - 1));
    endfunction

    // Presents one beat of two points and holds it until it is taken.
    task automatic send_points(input felem_t px, input felem_t py,
                               input felem_t qx, input felem_t qy);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({qy, qx, py, px});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_pair(input pair_kind_t kind);
        longint unsigned m;
        felem_t x;
        felem_t y;
        m = field_modulus();
        x = felem_t'($urandom_range(0, m - 1));
        y = felem_t'($urandom_range(0, m - 1));
        case (kind)
            PAIR_DOUBLE: begin
                send_points(alias_of(x), alias_of(y), alias_of(x), alias_of(y));
            end
            PAIR_NEGATED: begin
                send_points(alias_of(x), alias_of(y), alias_of(x), alias_of((m - y) % m));
            end
            PAIR_SHARED_X: begin
                send_points(alias_of(x), pick_coord(), alias_of(x), pick_coord());
            end
            default: begin
                send_points(pick_coord(), pick_coord(), pick_coord(), pick_coord());
            end
        endcase
    endtask

    // Waits until every result is back, with the input stream idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Writes both curve registers while the block is idle.
    task automatic configure(input felem_t a, input felem_t p);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_CURVE_A;
        cfg_wr_data <= a;
        @(posedge aclk);
        cfg_index   <= CFG_PRIME;
        cfg_wr_data <= p;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_prime   = p;
        settings_used++;
    endtask

    initial begin
        int pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: a is zero, the modulus is the largest prime.
        send_points(0, 0, 0, 0);
        send_points(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_points(0, COORD_MAX, COORD_MAX, 0);
        send_points(5, 7, 5, PRIME_MAX - 7);
        send_points(9, 4, 9, 10);
        send_points(1, 2, 3, 4);

        // Largest coefficient, with coordinates at or above the modulus.
        configure(COORD_MAX, 31'd2147483629);
        send_points(31'd123456789, 31'd987654321, 31'd123456789, 31'd987654321);
        send_points(31'd2147483640, 5, 11, 5);
        send_points(31'd2147483640, 31'd2147483646, 11, 12);

        // Smallest modulus.
        configure(5, MIN_PRIME);
        send_points(0, 1, 0, 2);
        send_points(1, 1, 1, 1);
        send_points(COORD_MAX, 0, 1, 2);

        // A modulus below 3 behaves as 3.
        configure(0, 2);
        send_points(1, 2, 2, 1);
        send_points(4, 4, 1, 1);
        configure(1, 0);
        send_points(1, 1, 2, 2);

        // Composite and even moduli.
        configure(7, 31'd1000001);
        send_points(3, 10, 500, 70);
        send_points(1000, 2000, 1000, 2000);
        configure(3, 31'd1000000);
        send_points(31'd1999999, 17, 31'd424242, 31'd777777);

        // Random phases over a range of curve settings; the last one runs without idling.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    configure(0, PRIME_MAX);
                    idle_odds = 4;
                end
                1: begin
                    configure(COORD_MAX, PRIME_MAX);
                    idle_odds = 0;
                end
                2: begin
                    configure(3, 31'd2147483629);
                    idle_odds = 3;
                end
                3: begin
                    configure(31'h2AAAAAAA, 31'd65521);
                    idle_odds = 2;
                end
                4: begin
                    configure(1, 31'd1000003);
                    idle_odds = 5;
                end
                5: begin
                    configure(7, 31'd13);
                    idle_odds = 2;
                end
                6: begin
                    configure(2, MIN_PRIME);
                    idle_odds = 3;
                end
                7: begin
                    configure(31'd1234567, 31'd1000001);
                    idle_odds = 4;
                end
                default: begin
                    configure(31'h55555555, 31'd2147483629);
                    idle_odds = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    send_pair(PAIR_GENERIC);
                end else if (pick < 75) begin
                    send_pair(PAIR_DOUBLE);
                end else if (pick < 88) begin
                    send_pair(PAIR_NEGATED);
                end else begin
                    send_pair(PAIR_SHARED_X);
                end
            end
        end

        // Let any stray beat show up before the verdict.
        drain();
        repeat (2500) @(posedge aclk);

        $display("Ran %0d curve settings: largest and smallest modulus, below 3, composite, even.",
                 settings_used);
        $display("Checked %0d sums, %0d at infinity, with idle bursts on both channels.",
                 checked_count, infinity_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ec_affine_point_add test passed");
        end else begin
            $display("ec_affine_point_add test failed");
        end
        $finish;
    end

    // Hard stop well past the slowest expected run.
    initial begin
        #(20_000_000);
        $display("Timeout: the run did not finish in time.");
        $display("ec_affine_point_add test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ecpa_pkg.sv
hw/rtl/ecpa_mulmod.sv
hw/rtl/ec_affine_point_add.sv
bench/point_sum_checker.sv
bench/testbench.sv
